>>> rtl/core/pr_pkg.sv
// Shared types and constants for the PageRank power-iteration block.
`default_nettype none
package pr_pkg;

  localparam int CFG_W = 17;
  localparam int G_W = 32;
  localparam int TOL_W = 16;
  localparam int OUT_W = 32;
  localparam int OUT_FRAC = 24;
  localparam int CAP_W = 12;

  localparam logic [16:0] D_ONE = 17'd65536;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_DAMPING    = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE  = 2'd2;
  localparam logic [1:0] CFG_ITER_CAP   = 2'd3;

  localparam logic [4:0]  NODE_COUNT_RST = 5'd16;
  localparam logic [16:0] DAMPING_RST    = 17'd55706;
  localparam logic [15:0] TOLERANCE_RST  = 16'd1;
  localparam logic [11:0] ITER_CAP_RST   = 12'd1000;

  typedef struct packed {
    logic link_bit;
    logic last_entry;
  } in_t;

  typedef struct packed {
    logic [3:0]  page_index;
    logic [31:0] raw_rank;
    logic [31:0] relative_rank;
    logic        converged;
    logic        last_rank;
  } out_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic shift;
    logic count;
  } pr_cmd_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_PREP, ST_INJ, ST_DRAIN, ST_CAPT, ST_SHIFT, ST_DECIDE,
    ST_KRD, ST_GA, ST_WA, ST_GB, ST_WB, ST_ORD, ST_OST, ST_OWT, ST_OHOLD
  } pr_state_t;

endpackage
`default_nettype wire

>>> rtl/core/pr_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module pr_div #(
  parameter int NUMW = 56,
  parameter int DENW = 32,
  localparam int CNTW = $clog2(NUMW)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quot
);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NUMW-1:0] num_r;
  logic [DENW-1:0] den_r;
  logic [DENW-1:0] rem_r;
  logic [DENW:0]   rem_sh;
  logic [DENW:0]   rem_sub;
  logic            ge;

  assign rem_sh  = {rem_r, num_r[NUMW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNTW'(NUMW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(NUMW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
      num_r <= {num_r[NUMW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule
`default_nettype wire

>>> rtl/core/pr_cell.sv
// One row cell: link row, column count, product accumulate and convergence test.
`default_nettype none
module pr_cell #(
  parameter int MAX_NODES = 16,
  parameter int RANK_WIDTH = 32,
  parameter int IDX = 0,
  localparam int AW = $clog2(MAX_NODES),
  localparam int NN = $clog2(MAX_NODES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [NN-1:0]         n,
  input  logic [15:0]           tol,
  input  pr_pkg::pr_cmd_t       cmd,
  input  logic                  wr_en,
  input  logic [NN-1:0]         wr_row,
  input  logic [AW-1:0]         wr_col,
  input  logic                  wr_bit,
  input  logic                  ti_v,
  input  logic [AW-1:0]         ti_col,
  input  logic [NN-1:0]         ti_cnt,
  input  logic [RANK_WIDTH-1:0] ti_rank,
  input  logic [31:0]           ti_gl,
  input  logic [31:0]           ti_gb,
  output logic                  to_v,
  output logic [AW-1:0]         to_col,
  output logic [NN-1:0]         to_cnt,
  output logic [RANK_WIDTH-1:0] to_rank,
  output logic [31:0]           to_gl,
  output logic [31:0]           to_gb,
  input  logic [RANK_WIDTH-1:0] so_i,
  output logic [RANK_WIDTH-1:0] so_o,
  output logic                  ok_o
);

  localparam int HW = RANK_WIDTH - 16;
  localparam int PW = RANK_WIDTH + 32;
  localparam int ACW = RANK_WIDTH + NN + 1;
  localparam int TW = RANK_WIDTH + 16;

  logic [MAX_NODES-1:0]  row_r;
  logic [MAX_NODES-1:0]  work_r;
  logic                  tv_r;
  logic [AW-1:0]         tcol_r;
  logic [NN-1:0]         tcnt_r;
  logic [RANK_WIDTH-1:0] trank_r;
  logic [31:0]           tgl_r;
  logic [31:0]           tgb_r;
  logic                  pv_r;
  logic [HW+31:0]        phi_r;
  logic [47:0]           plo_r;
  logic [ACW-1:0]        acc_r;
  logic [RANK_WIDTH-1:0] old_r;
  logic [TW-1:0]         told_r;
  logic [RANK_WIDTH-1:0] out_r;
  logic                  ok_r;

  logic                  active;
  logic                  lbit;
  logic [31:0]           g;
  logic [HW+31:0]        phi;
  logic [47:0]           plo;
  logic [PW:0]           psum;
  logic [RANK_WIDTH+1:0] rnd;
  logic [RANK_WIDTH-1:0] newv;
  logic [RANK_WIDTH-1:0] diff;

  assign active = NN'(IDX) < n;
  assign lbit   = work_r[0];
  assign g      = lbit ? ti_gl : ti_gb;
  assign phi    = (HW+32)'(ti_rank[RANK_WIDTH-1:16]) * (HW+32)'(g);
  assign plo    = 48'(ti_rank[15:0]) * 48'(g);
  assign psum   = (PW+1)'({phi_r, 16'b0}) + (PW+1)'(plo_r) + ((PW+1)'(1) << 30);
  assign rnd    = psum[PW:31];
  assign newv   = (acc_r > ACW'({RANK_WIDTH{1'b1}})) ? {RANK_WIDTH{1'b1}}
                                                    : acc_r[RANK_WIDTH-1:0];
  assign diff   = (old_r > newv) ? old_r - newv : newv - old_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      tv_r <= ti_v;
      pv_r <= ti_v & ~cmd.count;
    end
  end

  always_ff @(posedge clk) begin
    tcol_r  <= ti_col;
    tcnt_r  <= ti_cnt + NN'(cmd.count & active & lbit);
    trank_r <= ti_rank;
    tgl_r   <= ti_gl;
    tgb_r   <= ti_gb;
    phi_r   <= phi;
    plo_r   <= plo;
    if (wr_en && wr_row == NN'(IDX)) begin
      row_r[wr_col] <= wr_bit;
    end
    if (cmd.clear) begin
      work_r <= row_r;
    end else if (ti_v) begin
      work_r <= work_r >> 1;
    end
    if (cmd.clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + ACW'(rnd);
    end
    if (ti_v && !cmd.count && ti_col == AW'(IDX)) begin
      old_r  <= ti_rank;
      told_r <= TW'(tol) * TW'(ti_rank);
    end
    if (cmd.capture) begin
      out_r <= newv;
      ok_r  <= ~active | ({diff, 16'b0} < told_r);
    end else if (cmd.shift) begin
      out_r <= so_i;
    end
  end

  assign to_v    = tv_r;
  assign to_col  = tcol_r;
  assign to_cnt  = tcnt_r;
  assign to_rank = trank_r;
  assign to_gl   = tgl_r;
  assign to_gb   = tgb_r;
  assign so_o    = out_r;
  assign ok_o    = ok_r;

endmodule
`default_nettype wire

>>> rtl/core/pagerank_power_iteration.sv
// Top level of the PageRank power-iteration block: control, vector stores, cell chain.
// Link entries are taken one beat per cycle while loading; the beat marked last_entry
// starts a run, during which no input beat is taken. A run has a column-count pass
// through the cell chain, then two serial divisions per column to build the column
// coefficients, then per iteration one pass of the rank vector through the chain of
// MAX_NODES cells plus an unload shift. Each result beat then waits on the shared
// serial divider for the rank relative to page zero (NUMW = RANK_WIDTH + 24 by
// default) unless the relative rank saturates, and is held while out_stall is high.
`default_nettype none
module pagerank_power_iteration #(
  parameter int MAX_NODES = 16,
  parameter int RANK_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pr_pkg::in_t        in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pr_pkg::out_t       out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [pr_pkg::CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int NN = $clog2(MAX_NODES + 1);
  localparam int DCW = $clog2(MAX_NODES + 2);
  localparam int NUMW = (RANK_WIDTH + 24 > 33 + NN) ? RANK_WIDTH + 24 : 33 + NN;
  localparam int DENW = (RANK_WIDTH > 2 * NN + 1) ? RANK_WIDTH : 2 * NN + 1;
  localparam int VW = 18 + NN;
  localparam logic [RANK_WIDTH-1:0] RANK_ONE = RANK_WIDTH'(1) << (RANK_WIDTH - 8);

  logic [4:0]  node_count_r;
  logic [16:0] damping_r;
  logic [15:0] tol_r;
  logic [11:0] cap_r;

  pr_pkg::pr_state_t state_r, state_nxt;
  logic                  mode_r;
  logic                  first_r;
  logic [NN-1:0]         row_r;
  logic [NN-1:0]         col_r;
  logic [NN-1:0]         inj_r;
  logic [DCW-1:0]        drn_r;
  logic [AW-1:0]         sh_r;
  logic [NN-1:0]         j_r;
  logic [NN-1:0]         p_r;
  logic [11:0]           iter_r;
  logic                  conv_r;
  logic [RANK_WIDTH-1:0] r0_r;
  logic [31:0]           gl_r;
  logic [NN-1:0]         kd_r;
  logic [RANK_WIDTH-1:0] rk_rd_r;
  logic [63:0]           cf_rd_r;
  logic                  tokv_r;
  logic [AW-1:0]         tokcol_r;
  logic                  out_valid_r;
  pr_pkg::out_t          out_data_r;

  logic [RANK_WIDTH-1:0] rank_mem [MAX_NODES];
  logic [NN-1:0]         k_mem [MAX_NODES];
  logic [63:0]           cf_mem [MAX_NODES];

  logic [7:0]            nc8;
  logic [7:0]            n8;
  logic [NN-1:0]         n_w;
  logic [16:0]           d_w;
  logic [11:0]           cap_eff;
  logic                  accept;
  logic                  load_we;
  logic                  stop;
  logic                  all_ok;
  logic                  sat;
  logic                  out_last;
  logic [RANK_WIDTH+23:0] raw_sh;
  logic                  in_out_phase;

  pr_pkg::pr_cmd_t       cmd;
  logic                  div_start;
  logic                  div_done;
  logic [NUMW-1:0]       div_num;
  logic [DENW-1:0]       div_den;
  logic [NUMW-1:0]       div_q;
  logic [NN-1:0]         den_w;
  logic                  numsel;
  logic [VW-1:0]         value_w;
  logic [2*NN-1:0]       cc_w;

  logic                  tv_w    [MAX_NODES+1];
  logic [AW-1:0]         tc_w    [MAX_NODES+1];
  logic [NN-1:0]         tn_w    [MAX_NODES+1];
  logic [RANK_WIDTH-1:0] tr_w    [MAX_NODES+1];
  logic [31:0]           tgl_w   [MAX_NODES+1];
  logic [31:0]           tgb_w   [MAX_NODES+1];
  logic [RANK_WIDTH-1:0] so_w    [MAX_NODES+1];
  logic [MAX_NODES-1:0]  ok_v;

  assign nc8     = {3'b0, node_count_r};
  assign n8      = (nc8 == 8'd0) ? 8'd1 : ((nc8 > 8'(MAX_NODES)) ? 8'(MAX_NODES) : nc8);
  assign n_w     = n8[NN-1:0];
  assign d_w     = (damping_r > pr_pkg::D_ONE) ? pr_pkg::D_ONE : damping_r;
  assign cap_eff = (cap_r == 12'd0) ? 12'd1 : cap_r;
  assign accept  = in_valid & ~in_stall;
  assign load_we = accept & (row_r < n_w);
  assign all_ok  = &ok_v;
  assign stop    = all_ok | (({1'b0, iter_r} + 13'd1) >= {1'b0, cap_eff});
  assign sat     = (r0_r == '0) | ((RANK_WIDTH+8)'(rk_rd_r) >= {r0_r, 8'b0});
  assign out_last = (p_r + NN'(1)) == n_w;
  assign raw_sh  = {rk_rd_r, 24'b0} >> (RANK_WIDTH - 8);
  assign in_out_phase = (state_r == pr_pkg::ST_ORD) || (state_r == pr_pkg::ST_OST) ||
                        (state_r == pr_pkg::ST_OWT) || (state_r == pr_pkg::ST_OHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= pr_pkg::NODE_COUNT_RST;
      damping_r    <= pr_pkg::DAMPING_RST;
      tol_r        <= pr_pkg::TOLERANCE_RST;
      cap_r        <= pr_pkg::ITER_CAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pr_pkg::CFG_NODE_COUNT: node_count_r <= cfg_data[4:0];
        pr_pkg::CFG_DAMPING:    damping_r    <= cfg_data[16:0];
        pr_pkg::CFG_TOLERANCE:  tol_r        <= cfg_data[15:0];
        pr_pkg::CFG_ITER_CAP:   cap_r        <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pr_pkg::ST_LOAD:   if (accept && in_data.last_entry) state_nxt = pr_pkg::ST_PREP;
      pr_pkg::ST_PREP:   state_nxt = pr_pkg::ST_INJ;
      pr_pkg::ST_INJ:    if (inj_r == n_w) state_nxt = pr_pkg::ST_DRAIN;
      pr_pkg::ST_DRAIN:  if (drn_r == DCW'(MAX_NODES + 1)) state_nxt = pr_pkg::ST_CAPT;
      pr_pkg::ST_CAPT:   state_nxt = mode_r ? pr_pkg::ST_KRD : pr_pkg::ST_SHIFT;
      pr_pkg::ST_SHIFT:  if (sh_r == AW'(MAX_NODES - 1)) state_nxt = pr_pkg::ST_DECIDE;
      pr_pkg::ST_DECIDE: state_nxt = stop ? pr_pkg::ST_ORD : pr_pkg::ST_PREP;
      pr_pkg::ST_KRD:    state_nxt = pr_pkg::ST_GA;
      pr_pkg::ST_GA:     state_nxt = pr_pkg::ST_WA;
      pr_pkg::ST_WA:     if (div_done) state_nxt = pr_pkg::ST_GB;
      pr_pkg::ST_GB:     state_nxt = pr_pkg::ST_WB;
      pr_pkg::ST_WB: begin
        if (div_done) begin
          state_nxt = ((j_r + NN'(1)) == n_w) ? pr_pkg::ST_PREP : pr_pkg::ST_KRD;
        end
      end
      pr_pkg::ST_ORD:    state_nxt = pr_pkg::ST_OST;
      pr_pkg::ST_OST:    state_nxt = sat ? pr_pkg::ST_OHOLD : pr_pkg::ST_OWT;
      pr_pkg::ST_OWT:    if (div_done) state_nxt = pr_pkg::ST_OHOLD;
      pr_pkg::ST_OHOLD: begin
        if (!out_stall) state_nxt = out_last ? pr_pkg::ST_LOAD : pr_pkg::ST_ORD;
      end
      default:           state_nxt = pr_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall    = state_r != pr_pkg::ST_LOAD;
    cmd.clear   = state_r == pr_pkg::ST_PREP;
    cmd.capture = (state_r == pr_pkg::ST_CAPT) && !mode_r;
    cmd.shift   = state_r == pr_pkg::ST_SHIFT;
    cmd.count   = mode_r;
    div_start   = (state_r == pr_pkg::ST_GA) || (state_r == pr_pkg::ST_GB) ||
                  ((state_r == pr_pkg::ST_OST) && !sat);
    den_w       = (kd_r == '0) ? n_w : kd_r;
    numsel      = (state_r == pr_pkg::ST_GB) ? (kd_r == '0) : 1'b1;
    value_w     = VW'(pr_pkg::D_ONE - d_w) * VW'(den_w) +
                  (numsel ? VW'(d_w) * VW'(n_w) : VW'(0));
    cc_w        = (2*NN)'(n_w) * (2*NN)'(den_w);
    if (state_r == pr_pkg::ST_OST) begin
      div_num = NUMW'({rk_rd_r, 24'b0});
      div_den = DENW'(r0_r);
    end else begin
      div_num = (NUMW'(value_w) << 16) + NUMW'(cc_w);
      div_den = DENW'({cc_w, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pr_pkg::ST_LOAD;
      mode_r      <= 1'b0;
      first_r     <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      inj_r       <= '0;
      drn_r       <= '0;
      sh_r        <= '0;
      j_r         <= '0;
      p_r         <= '0;
      iter_r      <= '0;
      conv_r      <= 1'b0;
      tokv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tokv_r  <= (state_r == pr_pkg::ST_INJ) && (inj_r != n_w);
      case (state_r)
        pr_pkg::ST_LOAD: begin
          if (accept && in_data.last_entry) begin
            row_r  <= '0;
            col_r  <= '0;
            mode_r <= 1'b1;
          end else if (load_we) begin
            if (col_r == n_w - NN'(1)) begin
              col_r <= '0;
              row_r <= row_r + NN'(1);
            end else begin
              col_r <= col_r + NN'(1);
            end
          end
        end
        pr_pkg::ST_PREP: begin
          inj_r <= '0;
          drn_r <= '0;
        end
        pr_pkg::ST_INJ:   if (inj_r != n_w) inj_r <= inj_r + NN'(1);
        pr_pkg::ST_DRAIN: drn_r <= drn_r + DCW'(1);
        pr_pkg::ST_CAPT: begin
          sh_r <= '0;
          j_r  <= '0;
        end
        pr_pkg::ST_SHIFT: sh_r <= sh_r + AW'(1);
        pr_pkg::ST_DECIDE: begin
          iter_r  <= iter_r + 12'd1;
          first_r <= 1'b0;
          conv_r  <= all_ok;
          p_r     <= '0;
        end
        pr_pkg::ST_WB: begin
          if (div_done) begin
            j_r <= j_r + NN'(1);
            if ((j_r + NN'(1)) == n_w) begin
              mode_r  <= 1'b0;
              first_r <= 1'b1;
              iter_r  <= '0;
            end
          end
        end
        pr_pkg::ST_OST:   if (sat) out_valid_r <= 1'b1;
        pr_pkg::ST_OWT:   if (div_done) out_valid_r <= 1'b1;
        pr_pkg::ST_OHOLD: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            p_r         <= p_r + NN'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tokcol_r <= inj_r[AW-1:0];
    if (state_r == pr_pkg::ST_SHIFT && sh_r == AW'(MAX_NODES - 1)) begin
      r0_r <= so_w[MAX_NODES];
    end
    if (state_r == pr_pkg::ST_WA && div_done) begin
      gl_r <= div_q[31:0];
    end
    if ((state_r == pr_pkg::ST_OST && sat) || (state_r == pr_pkg::ST_OWT && div_done)) begin
      out_data_r.page_index    <= 4'(p_r);
      out_data_r.raw_rank      <= raw_sh[31:0];
      out_data_r.relative_rank <= sat ? 32'hFFFF_FFFF : div_q[31:0];
      out_data_r.converged     <= conv_r;
      out_data_r.last_rank     <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pr_pkg::ST_SHIFT) begin
      rank_mem[AW'(MAX_NODES - 1) - sh_r] <= so_w[MAX_NODES];
    end
    rk_rd_r <= rank_mem[in_out_phase ? p_r[AW-1:0] : inj_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tv_w[MAX_NODES] && mode_r) begin
      k_mem[tc_w[MAX_NODES]] <= tn_w[MAX_NODES];
    end
    kd_r <= k_mem[j_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == pr_pkg::ST_WB && div_done) begin
      cf_mem[j_r[AW-1:0]] <= {gl_r, div_q[31:0]};
    end
    cf_rd_r <= cf_mem[inj_r[AW-1:0]];
  end

  pr_div #(
    .NUMW (NUMW),
    .DENW (DENW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign tv_w[0]  = tokv_r;
  assign tc_w[0]  = tokcol_r;
  assign tn_w[0]  = '0;
  assign tr_w[0]  = first_r ? RANK_ONE : rk_rd_r;
  assign tgl_w[0] = cf_rd_r[63:32];
  assign tgb_w[0] = cf_rd_r[31:0];
  assign so_w[0]  = '0;

  for (genvar gi = 0; gi < MAX_NODES; gi++) begin : g_cell
    pr_cell #(
      .MAX_NODES  (MAX_NODES),
      .RANK_WIDTH (RANK_WIDTH),
      .IDX        (gi)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .n       (n_w),
      .tol     (tol_r),
      .cmd     (cmd),
      .wr_en   (load_we),
      .wr_row  (row_r),
      .wr_col  (col_r[AW-1:0]),
      .wr_bit  (in_data.link_bit),
      .ti_v    (tv_w[gi]),
      .ti_col  (tc_w[gi]),
      .ti_cnt  (tn_w[gi]),
      .ti_rank (tr_w[gi]),
      .ti_gl   (tgl_w[gi]),
      .ti_gb   (tgb_w[gi]),
      .to_v    (tv_w[gi+1]),
      .to_col  (tc_w[gi+1]),
      .to_cnt  (tn_w[gi+1]),
      .to_rank (tr_w[gi+1]),
      .to_gl   (tgl_w[gi+1]),
      .to_gb   (tgb_w[gi+1]),
      .so_i    (so_w[gi]),
      .so_o    (so_w[gi+1]),
      .ok_o    (ok_v[gi])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> bench/tb_pagerank_power_iteration.sv
// Self-checking testbench for the PageRank power-iteration block.
`default_nettype none
module tb_pagerank_power_iteration;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int RAND_ITEMS = 480;

  typedef struct {
    int unsigned n;
    int unsigned d;
    int unsigned tol;
    int unsigned cap;
    int unsigned cnt;
    logic [15:0] bits;
    bit          fixed;
    logic [31:0] e_raw;
    logic [31:0] e_rel;
    logic        e_conv;
  } dir_run_t;

  dir_run_t dir_tab [0:6] = '{
    '{1, 55706, 1, 1000, 1, 16'h0001, 1, 32'h0100_0000, 32'h0100_0000, 1'b1},
    '{1, 0, 0, 1, 1, 16'h0000, 1, 32'h0100_0000, 32'h0100_0000, 1'b0},
    '{0, 131071, 65535, 4095, 3, 16'h0005, 1, 32'h0100_0000, 32'h0100_0000, 1'b1},
    '{2, 65536, 65535, 1, 4, 16'h0000, 1, 32'h0100_0000, 32'h0100_0000, 1'b1},
    '{2, 65535, 300, 30, 4, 16'h000C, 0, 32'h0, 32'h0, 1'b0},
    '{2, 65536, 0, 2, 4, 16'h000C, 0, 32'h0, 32'h0, 1'b0},
    '{3, 32768, 655, 50, 9, 16'h0166, 0, 32'h0, 32'h0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pr_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pr_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = pr_pkg::CFG_NODE_COUNT;
  logic [pr_pkg::CFG_W-1:0] cfg_data = '0;

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned items = 0;
  int unsigned runs = 0;
  int unsigned checked = 0;
  int unsigned stall_left = 0;
  bit calm;

  // predictor state
  logic        link_mem [0:255];
  logic [31:0] gmat [0:255];
  logic [63:0] rk_old [0:15];
  logic [63:0] rk_new [0:15];
  int unsigned load_pos = 0;
  int unsigned m_nodes = 16, m_damp = 55706, m_tol = 1, m_cap = 1000;
  pr_pkg::out_t rank_q [$];

  pagerank_power_iteration dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  assign calm = ((cycles / 700) % 4) == 3;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned nodes_used();
    if (m_nodes == 0) return 1;
    if (m_nodes > 16) return 16;
    return m_nodes;
  endfunction

  function automatic logic [63:0] scale_rank(logic [63:0] g, logic [63:0] r);
    logic [63:0] hi, lo, rem;
    hi = (r >> 16) * g;
    lo = (r & 64'hFFFF) * g;
    rem = (hi & 64'h7FFF) << 16;
    return (hi >> 15) + ((rem + lo + (64'd1 << 30)) >> 31);
  endfunction

  function automatic logic [31:0] rank_ratio(logic [63:0] a, logic [63:0] b);
    logic [63:0] q, r, f;
    if (b == 0) return 32'hFFFF_FFFF;
    q = a / b;
    if (q >= 256) return 32'hFFFF_FFFF;
    r = a % b;
    f = 0;
    for (int s = 0; s < pr_pkg::OUT_FRAC; s++) begin
      r = r << 1;
      f = f << 1;
      if (r >= b) begin
        r = r - b;
        f = f | 64'd1;
      end
    end
    return 32'((q << pr_pkg::OUT_FRAC) | f);
  endfunction

  function automatic void build_google(int unsigned n);
    logic [63:0] d, num, den, val, dnm;
    int unsigned k;
    d = (m_damp > 65536) ? 64'd65536 : 64'(m_damp);
    for (int j = 0; j < n; j++) begin
      k = 0;
      for (int i = 0; i < n; i++) k += link_mem[i*16+j];
      for (int i = 0; i < n; i++) begin
        if (k == 0) begin
          num = 1;
          den = n;
        end else begin
          num = link_mem[i*16+j];
          den = k;
        end
        val = (64'd65536 - d) * den + d * num * n;
        dnm = 64'd65536 * n * den;
        gmat[i*16+j] = 32'(((val << 31) + dnm / 2) / dnm);
      end
    end
  endfunction

  function automatic void mat_vec(int unsigned n);
    logic [63:0] acc;
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < n; j++) acc += scale_rank(64'(gmat[i*16+j]), rk_old[j]);
      rk_new[i] = (acc > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : acc;
    end
  endfunction

  function automatic bit ranks_settled(int unsigned n);
    logic [63:0] df;
    for (int i = 0; i < n; i++) begin
      df = (rk_old[i] > rk_new[i]) ? rk_old[i] - rk_new[i] : rk_new[i] - rk_old[i];
      if (!((df << 16) < 64'(m_tol) * rk_old[i])) return 0;
    end
    return 1;
  endfunction

  // advance the predictor by one link beat; on the final beat queue the ranks
  function automatic void predict_ranks(logic lb, logic last);
    int unsigned n, cap, cnt;
    bit conv;
    pr_pkg::out_t r;
    n = nodes_used();
    if (load_pos < n * n) begin
      link_mem[(load_pos / n) * 16 + load_pos % n] = lb;
      load_pos++;
    end
    if (!last) return;
    load_pos = 0;
    build_google(n);
    cap = (m_cap == 0) ? 1 : m_cap;
    for (int i = 0; i < n; i++) rk_old[i] = 64'd1 << 24;
    mat_vec(n);
    cnt = 1;
    conv = ranks_settled(n);
    while (!conv && cnt < cap) begin
      for (int i = 0; i < n; i++) rk_old[i] = rk_new[i];
      mat_vec(n);
      cnt++;
      conv = ranks_settled(n);
    end
    for (int i = 0; i < n; i++) begin
      r.page_index = 4'(i);
      r.raw_rank = rk_new[i][31:0];
      r.relative_rank = rank_ratio(rk_new[i], rk_new[0]);
      r.converged = conv;
      r.last_rank = (i + 1 == n);
      rank_q.push_back(r);
    end
    runs++;
  endfunction

  task automatic send_link(logic lb, logic last);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    predict_ranks(lb, last);
    in_valid = 1'b1;
    in_data.link_bit = lb;
    in_data.last_entry = last;
    items++;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_ranks();
    in_valid = 1'b0;
    while (rank_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = pr_pkg::CFG_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      pr_pkg::CFG_NODE_COUNT: m_nodes = value & 32'h1F;
      pr_pkg::CFG_DAMPING: m_damp = value & 32'h1FFFF;
      pr_pkg::CFG_TOLERANCE: m_tol = value & 32'hFFFF;
      default: m_cap = value & 32'hFFF;
    endcase
  endtask

  task automatic set_config(int unsigned n, int unsigned d, int unsigned tol, int unsigned cap);
    drain_ranks();
    write_reg(pr_pkg::CFG_NODE_COUNT, n);
    write_reg(pr_pkg::CFG_DAMPING, d);
    write_reg(pr_pkg::CFG_TOLERANCE, tol);
    write_reg(pr_pkg::CFG_ITER_CAP, cap);
  endtask

  task automatic random_run(int unsigned density);
    int unsigned n, extra;
    n = nodes_used();
    extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    for (int k = 0; k < n * n + extra; k++) begin
      send_link($urandom_range(0, 99) < density, k == n * n + extra - 1);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    pr_pkg::out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rank_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected rank beat %p", $time, out_data);
      end else begin
        e = rank_q.pop_front();
        checked++;
        if (out_data.page_index !== e.page_index || out_data.raw_rank !== e.raw_rank ||
            out_data.relative_rank !== e.relative_rank ||
            out_data.converged !== e.converged || out_data.last_rank !== e.last_rank) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
        end
      end
    end
  end

  initial begin
    int unsigned n, big_left, long_left, nr, tol, cap, dens, start;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[r]) begin
      set_config(dir_tab[r].n, dir_tab[r].d, dir_tab[r].tol, dir_tab[r].cap);
      start = rank_q.size();
      for (int k = 0; k < dir_tab[r].cnt; k++) begin
        send_link(dir_tab[r].bits[k], k == dir_tab[r].cnt - 1);
      end
      if (dir_tab[r].fixed) begin
        for (int k = start; k < rank_q.size(); k++) begin
          rank_q[k].raw_rank = dir_tab[r].e_raw;
          rank_q[k].relative_rank = dir_tab[r].e_rel;
          rank_q[k].converged = dir_tab[r].e_conv;
        end
      end
    end

    big_left = 2;
    long_left = 1;
    start = items;
    while (items - start < RAND_ITEMS) begin
      case ($urandom_range(0, 19))
        0: n = 0;
        1: n = (big_left > 0 && items - start + 259 <= RAND_ITEMS) ?
               $urandom_range(16, 31) : 1;
        default: n = $urandom_range(1, 5);
      endcase
      if (n >= 16) big_left--;
      tol = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1) != 0) ? 65535 : 0)
                                        : $urandom_range(0, 2000);
      cap = $urandom_range(1, 40);
      if (long_left > 0 && n >= 1 && n <= 2 && tol == 0) begin
        cap = 4095;
        long_left--;
      end
      case ($urandom_range(0, 5))
        0: set_config(n, 0, tol, cap);
        1: set_config(n, 65536, tol, cap);
        2: set_config(n, $urandom_range(65537, 131071), tol, cap);
        default: set_config(n, $urandom_range(1, 65535), tol, cap);
      endcase
      nr = (n >= 16) ? 1 : $urandom_range(1, 3);
      for (int k = 0; k < nr; k++) begin
        dens = $urandom_range(0, 100);
        if ($urandom_range(0, 7) == 0) drain_ranks();
        random_run(dens);
      end
    end

    in_valid = 1'b0;
    while (rank_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("covered %0d link beats in %0d runs, %0d rank beats checked", items, runs, checked);
    $display("directed corner runs, then random graphs, damping, tolerances and caps");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/core/pr_pkg.sv
rtl/core/pr_div.sv
rtl/core/pr_cell.sv
rtl/core/pagerank_power_iteration.sv
bench/tb_pagerank_power_iteration.sv
